// File: hdl/stpq_pkg.sv
// Shared types and constants for the sorted time priority queue.
package stpq_pkg;

    localparam int TIME_W    = 48;
    localparam int TAG_W     = 16;
    localparam int OPC_W     = 2;
    localparam int STAT_W    = 3;
    localparam int OUT_CNT_W = 5;

    typedef enum logic [OPC_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_CHANGE = 2'd2,
        OP_PEEK   = 2'd3
    } t_opcode;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 3'd0,
        ST_PAST    = 3'd1,
        ST_FULL    = 3'd2,
        ST_EMPTY   = 3'd3,
        ST_EARLIER = 3'd4
    } t_status;

    typedef struct packed {
        logic shift;
        logic insert;
    } t_cell_cmd;

endpackage

// File: hdl/stpq_cell.sv
// One slot of the sorted chain: holds a deadline and tag, shifts or inserts.
module stpq_cell
    import stpq_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int CNT_W = 5
) (
    input  logic              i_clk,
    input  t_cell_cmd         i_cmd,
    input  logic [CNT_W-1:0]  i_count,
    input  logic [TIME_W-1:0] i_when,
    input  logic [TAG_W-1:0]  i_new_tag,
    input  logic              i_left_le,
    input  logic [TIME_W-1:0] i_left_deadline,
    input  logic [TAG_W-1:0]  i_left_tag,
    input  logic [TIME_W-1:0] i_right_deadline,
    input  logic [TAG_W-1:0]  i_right_tag,
    output logic              o_le,
    output logic [TIME_W-1:0] o_deadline,
    output logic [TAG_W-1:0]  o_tag,
    output logic [TIME_W-1:0] o_n_deadline,
    output logic [TAG_W-1:0]  o_n_tag
);

    logic [TIME_W-1:0] r_deadline;
    logic [TAG_W-1:0]  r_tag;
    logic [TIME_W-1:0] n_deadline;
    logic [TAG_W-1:0]  n_tag;
    logic              w_occ;

    assign w_occ = CNT_W'(IDX) < i_count;
    assign o_le  = w_occ && (r_deadline <= i_when);

    always_comb begin
        n_deadline = r_deadline;
        n_tag      = r_tag;
        if (i_cmd.shift) begin
            n_deadline = i_right_deadline;
            n_tag      = i_right_tag;
        end else if (i_cmd.insert && !o_le) begin
            if (i_left_le) begin
                n_deadline = i_when;
                n_tag      = i_new_tag;
            end else begin
                n_deadline = i_left_deadline;
                n_tag      = i_left_tag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_deadline <= n_deadline;
        r_tag      <= n_tag;
    end

    assign o_deadline   = r_deadline;
    assign o_tag        = r_tag;
    assign o_n_deadline = n_deadline;
    assign o_n_tag      = n_tag;

endmodule

// File: hdl/sorted_time_priority_queue.sv
// Top level: min-priority queue of timed tasks held in a sorted chain of cells.
// Results are registered: insert, remove and peek pass an execute state, change an execute
// state and then an insert state; each waits while an earlier result has not been taken.
// One item is handled at a time; change needs a shift-out step followed by an insert step.
// Reset (synchronous, active low) empties the queue and clears the output valid;
// cell contents stay undefined until written.
module sorted_time_priority_queue
    import stpq_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [111:0]  s_axis_tdata,   // deadline_ms[47:0], task_tag[63:48], now_ms[111:64]
    input  logic [1:0]    s_axis_tuser,   // opcode[1:0]
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [71:0]   m_axis_tdata,   // head_deadline[47:0], head_tag[63:48],
                                          // entry_count[68:64], zero[71:69]
    output logic [3:0]    m_axis_tuser    // status[2:0], head_valid[3]
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_INS
    } t_state;

    t_state             r_state, n_state;
    t_opcode            r_opc;
    logic [TIME_W-1:0]  r_when, r_now;
    logic [TAG_W-1:0]   r_tag, r_kept;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_out_valid;
    t_status            r_out_status, n_status;
    logic               r_out_hv;
    logic [TIME_W-1:0]  r_out_dl;
    logic [TAG_W-1:0]   r_out_tag;
    logic [OUT_CNT_W-1:0] r_out_cnt;

    t_cell_cmd          w_cmd;
    logic               w_go, w_load, w_kept_load;
    logic [TAG_W-1:0]   w_ins_tag;
    logic               w_le     [CAPACITY+1];
    logic [TIME_W-1:0]  w_dl     [CAPACITY];
    logic [TAG_W-1:0]   w_tg     [CAPACITY];
    logic [TIME_W-1:0]  w_n_dl   [CAPACITY];
    logic [TAG_W-1:0]   w_n_tg   [CAPACITY];

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_go          = !r_out_valid || m_axis_tready;
    assign w_ins_tag     = (r_state == S_INS) ? r_kept : r_tag;
    assign w_le[0]       = 1'b1;

    always_comb begin
        w_cmd       = '0;
        n_status    = ST_OK;
        n_state     = r_state;
        w_load      = 1'b0;
        w_kept_load = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_go) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                    unique case (r_opc)
                        OP_INSERT: begin
                            if (r_when <= r_now) begin
                                n_status = ST_PAST;
                            end else if (r_count == CNT_W'(CAPACITY)) begin
                                n_status = ST_FULL;
                            end else begin
                                w_cmd.insert = 1'b1;
                            end
                        end
                        OP_REMOVE: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                w_cmd.shift = 1'b1;
                            end
                        end
                        OP_CHANGE: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else if (r_when < w_dl[0]) begin
                                n_status = ST_EARLIER;
                            end else if (r_when <= r_now) begin
                                n_status = ST_PAST;
                            end else begin
                                w_cmd.shift = 1'b1;
                                w_kept_load = 1'b1;
                                w_load      = 1'b0;
                                n_state     = S_INS;
                            end
                        end
                        OP_PEEK: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end
                        end
                        default: begin
                            n_status = ST_OK;
                        end
                    endcase
                end
            end
            S_INS: begin
                if (w_go) begin
                    w_cmd.insert = 1'b1;
                    w_load       = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_count = r_count;
        if (w_cmd.insert) begin
            n_count = r_count + 1'b1;
        end else if (w_cmd.shift) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (s_axis_tvalid && s_axis_tready) begin
            r_opc  <= t_opcode'(s_axis_tuser);
            r_when <= s_axis_tdata[47:0];
            r_tag  <= s_axis_tdata[63:48];
            r_now  <= s_axis_tdata[111:64];
        end
        if (w_kept_load) begin
            r_kept <= w_tg[0];
        end
        if (w_load) begin
            r_out_status <= n_status;
            r_out_hv     <= (n_count != '0);
            r_out_dl     <= (n_count != '0) ? w_n_dl[0] : '0;
            r_out_tag    <= (n_count != '0) ? w_n_tg[0] : '0;
            r_out_cnt    <= OUT_CNT_W'(n_count);
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        localparam int RI = (g == CAPACITY - 1) ? g : g + 1;
        localparam int LI = (g == 0) ? 0 : g - 1;
        stpq_cell #(
            .IDX   (g),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk            (i_clk),
            .i_cmd            (w_cmd),
            .i_count          (r_count),
            .i_when           (r_when),
            .i_new_tag        (w_ins_tag),
            .i_left_le        (w_le[g]),
            .i_left_deadline  (w_dl[LI]),
            .i_left_tag       (w_tg[LI]),
            .i_right_deadline (w_dl[RI]),
            .i_right_tag      (w_tg[RI]),
            .o_le             (w_le[g+1]),
            .o_deadline       (w_dl[g]),
            .o_tag            (w_tg[g]),
            .o_n_deadline     (w_n_dl[g]),
            .o_n_tag          (w_n_tg[g])
        );
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out_cnt, r_out_tag, r_out_dl};
    assign m_axis_tuser  = {r_out_hv, r_out_status};

    a_count_max : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("queue count above capacity");

    a_head_order : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CNT_W'(2)) |-> (w_dl[0] <= w_dl[1]))
        else $error("head not earliest");

    a_ins_from_change : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INS) |-> (r_opc == OP_CHANGE && r_count < CNT_W'(CAPACITY)))
        else $error("reinsert step outside change");

    a_full_status : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && n_status == ST_FULL) |=> (r_count == CNT_W'(CAPACITY)))
        else $error("full reported below capacity");

    a_no_overwrite : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |-> !w_load)
        else $error("result overwritten before taken");

endmodule

// File: verif/sorted_time_priority_queue_tb.sv
// Self-checking testbench for the sorted time priority queue: directed and random stream traffic.
module sorted_time_priority_queue_tb;
    import stpq_pkg::*;

    localparam int CAPACITY   = 16;
    localparam int HOLD_LEN   = 80;
    localparam int TAIL_WAIT  = 8;

    typedef struct packed {
        t_status                status;
        logic                   head_valid;
        logic [TIME_W-1:0]      head_deadline;
        logic [TAG_W-1:0]       head_tag;
        logic [OUT_CNT_W-1:0]   entry_count;
    } t_outcome;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [111:0]       s_axis_tdata = '0;   // deadline_ms, task_tag, now_ms
    logic [1:0]         s_axis_tuser = '0;   // opcode
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [71:0]        m_axis_tdata;        // head_deadline, head_tag, entry_count, zero
    logic [3:0]         m_axis_tuser;        // status, head_valid

    logic [TIME_W-1:0]  sched_when [CAPACITY];
    logic [TAG_W-1:0]   sched_tag [CAPACITY];
    int                 held = 0;
    t_outcome           expected_heads [$];

    logic [TIME_W-1:0]  clock_ms = '0;
    bit                 sender_gaps = 1'b0;
    bit                 receiver_stalls = 1'b0;
    int                 hold_requests = 0;
    int                 hold_served = 0;
    int                 hold_left = 0;
    int                 stall_left = 0;
    int                 errors = 0;
    int                 results_seen = 0;
    int                 op_seen [4] = '{default: 0};
    int                 status_seen [5] = '{default: 0};

    sorted_time_priority_queue #(
        .CAPACITY(CAPACITY)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [TIME_W-1:0] rand_time();
        return TIME_W'({$urandom(), $urandom()});
    endfunction

    function automatic void sched_drop_head();
        for (int i = 1; i < held; i++) begin
            sched_when[i-1] = sched_when[i];
            sched_tag[i-1]  = sched_tag[i];
        end
        held--;
    endfunction

    function automatic void sched_place(logic [TIME_W-1:0] when, logic [TAG_W-1:0] tag);
        int pos;
        pos = 0;
        while (pos < held && sched_when[pos] <= when) pos++;
        for (int i = held; i > pos; i--) begin
            sched_when[i] = sched_when[i-1];
            sched_tag[i]  = sched_tag[i-1];
        end
        sched_when[pos] = when;
        sched_tag[pos]  = tag;
        held++;
    endfunction

    function automatic t_outcome apply_to_schedule(t_opcode op, logic [TIME_W-1:0] when,
                                                   logic [TAG_W-1:0] tag,
                                                   logic [TIME_W-1:0] now);
        t_outcome res;
        logic [TAG_W-1:0] kept;
        res.status = ST_OK;
        case (op)
            OP_INSERT: begin
                if (when <= now) res.status = ST_PAST;
                else if (held >= CAPACITY) res.status = ST_FULL;
                else sched_place(when, tag);
            end
            OP_REMOVE: begin
                if (held == 0) res.status = ST_EMPTY;
                else sched_drop_head();
            end
            OP_CHANGE: begin
                if (held == 0) res.status = ST_EMPTY;
                else if (when < sched_when[0]) res.status = ST_EARLIER;
                else if (when <= now) res.status = ST_PAST;
                else begin
                    kept = sched_tag[0];
                    sched_drop_head();
                    sched_place(when, kept);
                end
            end
            default: begin
                if (held == 0) res.status = ST_EMPTY;
            end
        endcase
        res.head_valid    = (held != 0);
        res.head_deadline = (held != 0) ? sched_when[0] : '0;
        res.head_tag      = (held != 0) ? sched_tag[0] : '0;
        res.entry_count   = OUT_CNT_W'(held);
        op_seen[op]++;
        status_seen[res.status]++;
        return res;
    endfunction

    task automatic sender_pause(input int cycles);
        s_axis_tvalid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic send_item(input t_opcode op, input logic [TIME_W-1:0] when,
                             input logic [TAG_W-1:0] tag, input logic [TIME_W-1:0] now);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {now, tag, when};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        expected_heads.push_back(apply_to_schedule(op, when, tag, now));
        if (sender_gaps && $urandom_range(0, 5) == 0) sender_pause($urandom_range(1, 5));
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_heads.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_random(input int insert_weight);
        int pick;
        t_opcode op;
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] when;
        clock_ms = clock_ms + TIME_W'($urandom_range(0, 2));
        now  = clock_ms;
        when = now + TIME_W'($urandom_range(1, 40));
        pick = $urandom_range(0, 99);
        if (pick < insert_weight) begin
            op = OP_INSERT;
        end else begin
            pick = $urandom_range(0, 99);
            op = (pick < 40) ? OP_REMOVE : (pick < 75) ? OP_CHANGE : OP_PEEK;
        end
        pick = $urandom_range(0, 99);
        if (op == OP_CHANGE && held != 0) begin
            when = sched_when[0] + TIME_W'($urandom_range(0, 30));
            now  = when - TIME_W'($urandom_range(1, 20));
            if (pick < 8) when = sched_when[0] - TIME_W'($urandom_range(1, 10));
            else if (pick < 16) now = when + TIME_W'($urandom_range(0, 5));
        end else if (pick < 10) begin
            when = now - TIME_W'($urandom_range(0, 5));
        end else if (pick < 15) begin
            when = rand_time();
            now  = rand_time();
        end
        send_item(op, when, TAG_W'($urandom()), now);
    endtask

    task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (expected_heads.size() == 0) begin
                $display("%0t: result with nothing expected, expected none, actual %h/%h",
                         $time, m_axis_tdata, m_axis_tuser);
                errors++;
            end else begin
                want = expected_heads.pop_front();
                check_field("status", want.status, m_axis_tuser[2:0]);
                check_field("head_valid", want.head_valid, m_axis_tuser[3]);
                check_field("head_deadline", want.head_deadline, m_axis_tdata[47:0]);
                check_field("head_tag", want.head_tag, m_axis_tdata[63:48]);
                check_field("entry_count", want.entry_count, m_axis_tdata[68:64]);
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_requests != hold_served) begin
            hold_served   <= hold_requests;
            hold_left     <= HOLD_LEN;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (receiver_stalls && $urandom_range(0, 6) == 0) begin
            stall_left    <= $urandom_range(0, 4);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic test_empty_queue();
        send_item(OP_PEEK, rand_time(), TAG_W'($urandom()), rand_time());
        send_item(OP_REMOVE, rand_time(), TAG_W'($urandom()), rand_time());
        send_item(OP_CHANGE, rand_time(), TAG_W'($urandom()), rand_time());
        send_item(OP_INSERT, '0, 16'hffff, '0);
        send_item(OP_INSERT, TIME_W'(5), 16'h1234, TIME_W'(9));
        send_item(OP_INSERT, TIME_W'(1), 16'h0000, '0);
        send_item(OP_PEEK, '0, '0, '0);
        send_item(OP_REMOVE, '0, '0, '0);
    endtask

    task automatic test_order_and_change();
        send_item(OP_INSERT, TIME_W'(100), 16'h0001, TIME_W'(10));
        send_item(OP_INSERT, TIME_W'(50), 16'h0002, TIME_W'(10));
        send_item(OP_INSERT, TIME_W'(100), 16'h0003, TIME_W'(10));
        send_item(OP_INSERT, TIME_W'(75), 16'h0004, TIME_W'(10));
        send_item(OP_PEEK, '0, '0, '0);
        send_item(OP_CHANGE, TIME_W'(40), '0, TIME_W'(10));
        send_item(OP_CHANGE, TIME_W'(60), '0, TIME_W'(60));
        send_item(OP_CHANGE, TIME_W'(100), '0, TIME_W'(10));
        send_item(OP_CHANGE, TIME_W'(75), '0, TIME_W'(10));
        send_item(OP_CHANGE, TIME_W'(100), '0, TIME_W'(10));
        send_item(OP_CHANGE, TIME_W'(100), '0, TIME_W'(99));
        send_item(OP_INSERT, '1, 16'hffff, '1 - TIME_W'(1));
        send_item(OP_INSERT, '1, 16'haaaa, '1);
        repeat (6) send_item(OP_REMOVE, '0, '0, '0);
        wait_drained();
    endtask

    task automatic test_backpressure();
        hold_requests <= hold_requests + 1;
        repeat (24) send_item(OP_INSERT, clock_ms + TIME_W'($urandom_range(1, 200)),
                              TAG_W'($urandom()), clock_ms);
        wait_drained();
    endtask

    task automatic test_random_traffic();
        sender_gaps = 1'b1;
        receiver_stalls <= 1'b1;
        clock_ms = rand_time();
        for (int seg = 0; seg < 15; seg++) begin
            if (seg == 7) clock_ms = rand_time();
            repeat (60) send_random((seg % 2 == 0) ? 70 : 15);
        end
        wait_drained();
    endtask

    task automatic test_streaming();
        sender_gaps = 1'b0;
        receiver_stalls <= 1'b0;
        repeat (150) send_random(50);
        wait_drained();
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_queue();
        test_order_and_change();
        clock_ms = rand_time();
        test_backpressure();
        test_random_traffic();
        test_streaming();
        repeat (TAIL_WAIT) @(posedge i_clk);
        $display("items: %0d insert, %0d remove, %0d change, %0d peek; results checked: %0d",
                 op_seen[OP_INSERT], op_seen[OP_REMOVE], op_seen[OP_CHANGE],
                 op_seen[OP_PEEK], results_seen);
        $display("outcomes: %0d ok, %0d past, %0d full, %0d empty, %0d earlier",
                 status_seen[ST_OK], status_seen[ST_PAST], status_seen[ST_FULL],
                 status_seen[ST_EMPTY], status_seen[ST_EARLIER]);
        if (errors == 0) begin
            $display("sorted_time_priority_queue_tb: done, clean");
        end else begin
            $display("sorted_time_priority_queue_tb: done, errors");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("%0t: timeout", $time);
        $display("sorted_time_priority_queue_tb: done, errors");
        $finish;
    end

endmodule

// File: files.f
hdl/stpq_pkg.sv
hdl/stpq_cell.sv
hdl/sorted_time_priority_queue.sv
verif/sorted_time_priority_queue_tb.sv
